// ----- src/assert_macros.svh -----
// Assertion macros shared by the battery cycle relay controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BCRC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BCRC_ASSERT(lbl, expr, msg)
`define BCRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/bcrc_pkg.sv -----
// Types, constants and sizes shared by the battery cycle relay controller.
package bcrc_pkg;

    localparam int WINDOW   = 100;
    localparam int CODE_W   = 12;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int SUM_W    = CODE_W + $clog2(WINDOW);

    // floor(sum / WINDOW) as (sum * RECIP) >> RECIP_SHIFT, exact for any SUM_W-bit sum
    localparam int     RECIP_SHIFT = SUM_W + 8;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int     RECIP_W     = RECIP_SHIFT - $clog2(WINDOW) + 1;
    localparam int     PROD_W      = SUM_W + RECIP_W;

    localparam int IN_DEPTH  = 2;
    localparam int IPTR_W    = $clog2(IN_DEPTH);
    localparam int ICNT_W    = $clog2(IN_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 4);

    localparam int IN_FIELDS_W  = 3 * CODE_W + 2;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * CODE_W + 5;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CHARGE_CUTOFF_RST    = code_t'(2769);
    localparam code_t DISCHARGE_CUTOFF_RST = code_t'(1868);
    localparam code_t HOT_RST              = code_t'(2851);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHARGE_CUTOFF    = 2'd0,
        CFG_DISCHARGE_CUTOFF = 2'd1,
        CFG_HOT              = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CHARGE    = 2'd1,
        MODE_DISCHARGE = 2'd2
    } relay_mode_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_IDLE      = 2'd1,
        CMD_CHARGE    = 2'd2,
        CMD_DISCHARGE = 2'd3
    } cmd_t;

    typedef struct packed {
        code_t charge_cutoff;
        code_t discharge_cutoff;
        code_t hot;
    } cfg_t;

    typedef struct packed {
        code_t       voltage;
        code_t       current;
        code_t       temp;
        logic        cmd_valid;
        relay_mode_t cmd_mode;
    } item_t;

    typedef struct packed {
        relay_mode_t mode;
        logic        relay_one;
        logic        relay_two;
        code_t       avg_voltage;
        code_t       avg_current;
        logic        window_full;
    } result_t;

endpackage

// ----- src/bcrc_front.sv -----
// Front end: takes input items, decodes the command, and queues them for the back end.
module bcrc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bcrc_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            pop,
    output logic                            q_valid,
    output bcrc_pkg::item_t                 q_item
);

    bcrc_pkg::item_t              q_mem [bcrc_pkg::IN_DEPTH];
    bcrc_pkg::item_t              in_item;
    bcrc_pkg::cmd_t               cmd;
    logic [bcrc_pkg::IPTR_W-1:0]  wr_ptr_reg;
    logic [bcrc_pkg::IPTR_W-1:0]  rd_ptr_reg;
    logic [bcrc_pkg::ICNT_W-1:0]  count_reg;
    logic [bcrc_pkg::ICNT_W-1:0]  count_next;
    logic                         push;

    assign cmd = bcrc_pkg::cmd_t'(s_tdata[3*bcrc_pkg::CODE_W +: 2]);

    always_comb
    begin
        in_item.voltage = s_tdata[0 +: bcrc_pkg::CODE_W];
        in_item.current = s_tdata[bcrc_pkg::CODE_W +: bcrc_pkg::CODE_W];
        in_item.temp    = s_tdata[2*bcrc_pkg::CODE_W +: bcrc_pkg::CODE_W];
        unique case (cmd)
            bcrc_pkg::CMD_IDLE:
            begin
                in_item.cmd_valid = 1'b1;
                in_item.cmd_mode  = bcrc_pkg::MODE_IDLE;
            end
            bcrc_pkg::CMD_CHARGE:
            begin
                in_item.cmd_valid = 1'b1;
                in_item.cmd_mode  = bcrc_pkg::MODE_CHARGE;
            end
            bcrc_pkg::CMD_DISCHARGE:
            begin
                in_item.cmd_valid = 1'b1;
                in_item.cmd_mode  = bcrc_pkg::MODE_DISCHARGE;
            end
            default:
            begin
                in_item.cmd_valid = 1'b0;
                in_item.cmd_mode  = bcrc_pkg::MODE_IDLE;
            end
        endcase
    end

    assign s_tready = (count_reg != bcrc_pkg::ICNT_W'(bcrc_pkg::IN_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    // depth is a power of two, so the pointers wrap on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_item;
    end

endmodule

// ----- src/bcrc_back.sv -----
// Back end: ring memory and running sums, window average, relay state, result buffer.
`include "assert_macros.svh"

module bcrc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bcrc_pkg::item_t   q_item,
    output logic              q_pop,
    input  bcrc_pkg::cfg_t    cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output bcrc_pkg::result_t m_result
);

    typedef struct packed {
        bcrc_pkg::relay_mode_t mode;
        logic                  one;
        logic                  two;
    } relay_t;

    typedef struct packed {
        bcrc_pkg::code_t       temp;
        logic                  cmd_valid;
        bcrc_pkg::relay_mode_t cmd_mode;
        logic                  wrap;
        logic                  full;
    } ctl_t;

    localparam logic [bcrc_pkg::RECIP_W-1:0] RECIP_K = bcrc_pkg::RECIP_W'(bcrc_pkg::RECIP);

    function automatic relay_t relay_step(input relay_t cur, input bcrc_pkg::code_t avg,
                                          input bcrc_pkg::cfg_t c);
        relay_t r;
        r = cur;
        unique case (cur.mode)
            bcrc_pkg::MODE_CHARGE:
            begin
                r.one = 1'b0;
                r.two = 1'b1;
                if (avg >= c.charge_cutoff)
                    r.mode = bcrc_pkg::MODE_IDLE;
            end
            bcrc_pkg::MODE_DISCHARGE:
            begin
                r.one = 1'b1;
                r.two = 1'b0;
                if (avg <= c.discharge_cutoff)
                    r.mode = bcrc_pkg::MODE_IDLE;
            end
            default:
            begin
                r.mode = bcrc_pkg::MODE_IDLE;
                r.one  = 1'b1;
                r.two  = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ring: voltage in the low half, current in the high half
    logic [2*bcrc_pkg::CODE_W-1:0] ring_mem [bcrc_pkg::WINDOW];
    logic [2*bcrc_pkg::CODE_W-1:0] ring_rd_reg;

    logic                          issue;
    logic [bcrc_pkg::OCC_W-1:0]    occupancy;

    // stage B: ring update
    logic                          b_valid_reg;
    bcrc_pkg::item_t               b_item_reg;
    logic [bcrc_pkg::IDX_W-1:0]    idx_reg;
    logic [bcrc_pkg::IDX_W-1:0]    idx_next;
    logic                          full_reg;
    logic                          full_next;
    logic                          wrap;
    logic [bcrc_pkg::SUM_W-1:0]    sum_v_reg;
    logic [bcrc_pkg::SUM_W-1:0]    sum_v_next;
    logic [bcrc_pkg::SUM_W-1:0]    sum_c_reg;
    logic [bcrc_pkg::SUM_W-1:0]    sum_c_next;
    bcrc_pkg::code_t               old_v;
    bcrc_pkg::code_t               old_c;

    // stage C: divide by the window
    logic                          c_valid_reg;
    ctl_t                          c_ctl_reg;

    // stage D: relay decisions
    logic                          d_valid_reg;
    ctl_t                          d_ctl_reg;
    logic [bcrc_pkg::PROD_W-1:0]   prod_v_reg;
    logic [bcrc_pkg::PROD_W-1:0]   prod_c_reg;
    bcrc_pkg::code_t               avg_v_new;
    bcrc_pkg::code_t               avg_c_new;

    bcrc_pkg::relay_mode_t         mode_reg;
    logic                          one_reg;
    logic                          two_reg;
    bcrc_pkg::code_t               avg_v_reg;
    bcrc_pkg::code_t               avg_v_next;
    bcrc_pkg::code_t               avg_c_reg;
    bcrc_pkg::code_t               avg_c_next;
    bcrc_pkg::code_t               held_reg;
    bcrc_pkg::code_t               held_next;
    relay_t                        relay_next;
    bcrc_pkg::result_t             result;

    // result buffer
    bcrc_pkg::result_t             ofifo [bcrc_pkg::OUT_DEPTH];
    logic [bcrc_pkg::OPTR_W-1:0]   owr_reg;
    logic [bcrc_pkg::OPTR_W-1:0]   ord_reg;
    logic [bcrc_pkg::OCNT_W-1:0]   ocount_reg;
    logic [bcrc_pkg::OCNT_W-1:0]   ocount_next;
    logic                          opop;

    // items in flight plus buffered results never exceed the buffer depth
    assign occupancy = bcrc_pkg::OCC_W'(ocount_reg) + bcrc_pkg::OCC_W'(b_valid_reg)
                     + bcrc_pkg::OCC_W'(c_valid_reg) + bcrc_pkg::OCC_W'(d_valid_reg);
    // no issue while stage B holds an item: its index and ring write are not done yet
    assign issue = q_valid && !b_valid_reg
                && (occupancy < bcrc_pkg::OCC_W'(bcrc_pkg::OUT_DEPTH));
    assign q_pop = issue;

    // ---- stage B ----
    assign old_v = full_reg ? ring_rd_reg[0 +: bcrc_pkg::CODE_W] : '0;
    assign old_c = full_reg ? ring_rd_reg[bcrc_pkg::CODE_W +: bcrc_pkg::CODE_W] : '0;
    assign sum_v_next = sum_v_reg - bcrc_pkg::SUM_W'(old_v)
                      + bcrc_pkg::SUM_W'(b_item_reg.voltage);
    assign sum_c_next = sum_c_reg - bcrc_pkg::SUM_W'(old_c)
                      + bcrc_pkg::SUM_W'(b_item_reg.current);
    assign wrap      = (idx_reg == bcrc_pkg::IDX_W'(bcrc_pkg::WINDOW - 1));
    assign idx_next  = wrap ? '0 : idx_reg + 1'b1;
    assign full_next = full_reg | wrap;

    always_ff @(posedge clk)
    begin
        if (issue)
            ring_rd_reg <= ring_mem[idx_reg];
        if (b_valid_reg)
            ring_mem[idx_reg] <= {b_item_reg.current, b_item_reg.voltage};
    end

    // ---- stage D ----
    assign avg_v_new = prod_v_reg[bcrc_pkg::RECIP_SHIFT +: bcrc_pkg::CODE_W];
    assign avg_c_new = prod_c_reg[bcrc_pkg::RECIP_SHIFT +: bcrc_pkg::CODE_W];

    always_comb
    begin
        relay_next = '{mode: mode_reg, one: one_reg, two: two_reg};
        // wrap step sees the average from before this item
        if (d_ctl_reg.wrap)
            relay_next = relay_step(relay_next, avg_v_reg, cfg);
        avg_v_next = d_ctl_reg.full ? avg_v_new : avg_v_reg;
        avg_c_next = d_ctl_reg.full ? avg_c_new : avg_c_reg;
        held_next  = d_ctl_reg.full ? d_ctl_reg.temp : held_reg;
        if (held_next != '0 && held_next >= cfg.hot)
            relay_next.mode = bcrc_pkg::MODE_IDLE;
        if (d_ctl_reg.cmd_valid)
        begin
            relay_next.mode = d_ctl_reg.cmd_mode;
            relay_next      = relay_step(relay_next, avg_v_next, cfg);
        end
        result.mode        = relay_next.mode;
        result.relay_one   = relay_next.one;
        result.relay_two   = relay_next.two;
        result.avg_voltage = avg_v_next;
        result.avg_current = avg_c_next;
        result.window_full = d_ctl_reg.full;
    end

    // ---- result buffer ----
    assign m_valid  = (ocount_reg != '0);
    assign m_result = ofifo[ord_reg];
    assign opop     = m_valid && m_ready;

    always_comb
    begin
        ocount_next = ocount_reg;
        if (d_valid_reg && !opop)
            ocount_next = ocount_reg + 1'b1;
        else if (!d_valid_reg && opop)
            ocount_next = ocount_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (d_valid_reg)
            ofifo[owr_reg] <= result;
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (issue)
            b_item_reg <= q_item;
        if (b_valid_reg)
        begin
            c_ctl_reg.temp      <= b_item_reg.temp;
            c_ctl_reg.cmd_valid <= b_item_reg.cmd_valid;
            c_ctl_reg.cmd_mode  <= b_item_reg.cmd_mode;
            c_ctl_reg.wrap      <= wrap;
            c_ctl_reg.full      <= full_next;
        end
        if (c_valid_reg)
        begin
            d_ctl_reg  <= c_ctl_reg;
            prod_v_reg <= bcrc_pkg::PROD_W'(sum_v_reg) * bcrc_pkg::PROD_W'(RECIP_K);
            prod_c_reg <= bcrc_pkg::PROD_W'(sum_c_reg) * bcrc_pkg::PROD_W'(RECIP_K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            idx_reg     <= '0;
            full_reg    <= 1'b0;
            sum_v_reg   <= '0;
            sum_c_reg   <= '0;
            mode_reg    <= bcrc_pkg::MODE_IDLE;
            one_reg     <= 1'b0;
            two_reg     <= 1'b0;
            avg_v_reg   <= '0;
            avg_c_reg   <= '0;
            held_reg    <= '0;
            owr_reg     <= '0;
            ord_reg     <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            b_valid_reg <= issue;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            if (b_valid_reg)
            begin
                idx_reg   <= idx_next;
                full_reg  <= full_next;
                sum_v_reg <= sum_v_next;
                sum_c_reg <= sum_c_next;
            end
            if (d_valid_reg)
            begin
                mode_reg  <= relay_next.mode;
                one_reg   <= relay_next.one;
                two_reg   <= relay_next.two;
                avg_v_reg <= avg_v_next;
                avg_c_reg <= avg_c_next;
                held_reg  <= held_next;
                owr_reg   <= owr_reg + 1'b1;
            end
            if (opop)
                ord_reg <= ord_reg + 1'b1;
            ocount_reg <= ocount_next;
        end
    end

    `BCRC_ASSERT(a_occ_bound, occupancy <= bcrc_pkg::OCC_W'(bcrc_pkg::OUT_DEPTH), "result credit overrun")
    `BCRC_ASSERT(a_push_room, !d_valid_reg || ocount_reg < bcrc_pkg::OCNT_W'(bcrc_pkg::OUT_DEPTH), "result buffer overflow")
    `BCRC_ASSERT_NEXT(a_full_sticky, full_reg, full_reg, "window full flag dropped")
    `BCRC_ASSERT(a_idx_range, {1'b0, idx_reg} < (bcrc_pkg::IDX_W + 1)'(bcrc_pkg::WINDOW), "ring index out of range")

endmodule

// ----- src/battery_cycle_relay_controller.sv -----
// Top level of the battery cycle relay controller: config registers, front, back, packing.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           voltage, current, temp, command
//  m_axis    out        tvalid/tready           relay mode, relay pins, averages, full
//  cfg       in         cfg_wr_en (no wait)     cutoff and hot thresholds
//
// The back end takes no new item while the last one is still in stage B: the ring
// memory is read when an item issues and written when it reaches stage B.
// Reset is asynchronous; the ring needs no clearing pass, since old ring entries are
// taken as zero until the window has filled once. Up to four results buffer at the
// output; the input stalls once they and the two-entry input queue are taken.
module battery_cycle_relay_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] voltage_code, [23:12] current_code, [35:24] temp_code, [37:36] command
    input  logic [bcrc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] relay_mode, [2] relay_one, [3] relay_two, [15:4] avg_voltage,
    // [27:16] avg_current, [28] window_full
    output logic [bcrc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bcrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bcrc_pkg::CODE_W-1:0]         cfg_data
);

    bcrc_pkg::cfg_t    cfg_reg;
    bcrc_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_pop;
    bcrc_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_cutoff    <= bcrc_pkg::CHARGE_CUTOFF_RST;
            cfg_reg.discharge_cutoff <= bcrc_pkg::DISCHARGE_CUTOFF_RST;
            cfg_reg.hot              <= bcrc_pkg::HOT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bcrc_pkg::CFG_CHARGE_CUTOFF:    cfg_reg.charge_cutoff    <= cfg_data;
                bcrc_pkg::CFG_DISCHARGE_CUTOFF: cfg_reg.discharge_cutoff <= cfg_data;
                bcrc_pkg::CFG_HOT:              cfg_reg.hot              <= cfg_data;
                default:                        ;
            endcase
        end
    end

    bcrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    bcrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    assign m_axis_tdata = {(bcrc_pkg::OUT_TDATA_W - bcrc_pkg::OUT_FIELDS_W)'(0),
                           result.window_full, result.avg_current, result.avg_voltage,
                           result.relay_two, result.relay_one, result.mode};

endmodule

// ----- bench/battery_cycle_relay_controller_tb.sv -----
// Self-checking bench for the battery cycle relay controller: stream driver, monitor, predictor.
module battery_cycle_relay_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 8;
    localparam logic [bcrc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct {
        bcrc_pkg::code_t voltage;
        bcrc_pkg::code_t current;
        bcrc_pkg::code_t temp;
        bcrc_pkg::cmd_t  cmd;
    } loop_sample_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [bcrc_pkg::IN_TDATA_W-1:0]        s_axis_tdata = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [bcrc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata;
    logic                                   cfg_wr_en = 1'b0;
    logic [bcrc_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    bcrc_pkg::code_t                        cfg_data = '0;

    battery_cycle_relay_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    bcrc_pkg::code_t            thr_charge = bcrc_pkg::CHARGE_CUTOFF_RST;
    bcrc_pkg::code_t            thr_discharge = bcrc_pkg::DISCHARGE_CUTOFF_RST;
    bcrc_pkg::code_t            thr_hot = bcrc_pkg::HOT_RST;
    bcrc_pkg::code_t            volt_ring [bcrc_pkg::WINDOW];
    bcrc_pkg::code_t            amp_ring [bcrc_pkg::WINDOW];
    logic [bcrc_pkg::SUM_W-1:0] volt_sum = '0;
    logic [bcrc_pkg::SUM_W-1:0] amp_sum = '0;
    int                         ring_pos = 0;
    logic                       window_done = 1'b0;
    bcrc_pkg::relay_mode_t      relay_state = bcrc_pkg::MODE_IDLE;
    logic                       pin_one = 1'b0;
    logic                       pin_two = 1'b0;
    bcrc_pkg::code_t            avg_volt = '0;
    bcrc_pkg::code_t            avg_amp = '0;
    bcrc_pkg::code_t            held_temp = '0;

    loop_sample_t               sample_queue [$];
    loop_sample_t               sample_in_flight;
    bcrc_pkg::result_t          relay_expected [$];

    int                     send_gap = 0;
    int                     hold_left = 0;
    bit                     long_hold_done = 1'b0;
    bit                     phase_calm = 1'b0;
    int                     items_queued = 0;
    int                     items_accepted = 0;
    int                     results_checked = 0;
    int                     mismatches = 0;
    int                     settings_used = 1;
    int                     charge_stops = 0;
    int                     discharge_stops = 0;
    int                     hot_trips = 0;
    int                     cycle_count = 0;
    int                     walk_v = 2000;
    int                     walk_drift = 0;

    function void drive_relays();
        if (relay_state == bcrc_pkg::MODE_CHARGE)
        begin
            pin_one = 1'b0;
            pin_two = 1'b1;
            if (avg_volt >= thr_charge)
            begin
                relay_state = bcrc_pkg::MODE_IDLE;
                charge_stops++;
            end
        end
        else if (relay_state == bcrc_pkg::MODE_DISCHARGE)
        begin
            pin_one = 1'b1;
            pin_two = 1'b0;
            if (avg_volt <= thr_discharge)
            begin
                relay_state = bcrc_pkg::MODE_IDLE;
                discharge_stops++;
            end
        end
        else
        begin
            relay_state = bcrc_pkg::MODE_IDLE;
            pin_one = 1'b1;
            pin_two = 1'b1;
        end
    endfunction

    function automatic bcrc_pkg::result_t advance_controller(loop_sample_t s);
        bcrc_pkg::result_t r;
        int                slot;
        slot = ring_pos;
        volt_sum = volt_sum - volt_ring[slot] + s.voltage;
        amp_sum = amp_sum - amp_ring[slot] + s.current;
        volt_ring[slot] = s.voltage;
        amp_ring[slot] = s.current;
        ring_pos = slot + 1;
        // wrap: relay step sees the voltage average from before this pass
        if (ring_pos >= bcrc_pkg::WINDOW)
        begin
            ring_pos = 0;
            window_done = 1'b1;
            drive_relays();
        end
        if (window_done)
        begin
            avg_volt = bcrc_pkg::code_t'(volt_sum / bcrc_pkg::WINDOW);
            avg_amp = bcrc_pkg::code_t'(amp_sum / bcrc_pkg::WINDOW);
            held_temp = s.temp;
        end
        if (held_temp != '0 && held_temp >= thr_hot)
        begin
            if (relay_state != bcrc_pkg::MODE_IDLE)
                hot_trips++;
            relay_state = bcrc_pkg::MODE_IDLE;
        end
        if (s.cmd != bcrc_pkg::CMD_NONE)
        begin
            case (s.cmd)
                bcrc_pkg::CMD_CHARGE:    relay_state = bcrc_pkg::MODE_CHARGE;
                bcrc_pkg::CMD_DISCHARGE: relay_state = bcrc_pkg::MODE_DISCHARGE;
                default:                 relay_state = bcrc_pkg::MODE_IDLE;
            endcase
            drive_relays();
        end
        r.mode = relay_state;
        r.relay_one = pin_one;
        r.relay_two = pin_two;
        r.avg_voltage = avg_volt;
        r.avg_current = avg_amp;
        r.window_full = window_done;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic loop_sample_t make_sample(int v, int i, int t, bcrc_pkg::cmd_t c);
        loop_sample_t s;
        s.voltage = bcrc_pkg::code_t'(v);
        s.current = bcrc_pkg::code_t'(i);
        s.temp = bcrc_pkg::code_t'(t);
        s.cmd = c;
        return s;
    endfunction

    // Voltage follows a random walk that climbs while charging and sinks while
    // discharging, so window averages cross the cutoffs.
    function automatic loop_sample_t random_sample();
        loop_sample_t s;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 3)
            walk_v = $urandom_range(0, 4095);
        else
            walk_v = walk_v + walk_drift + int'($urandom_range(0, 30)) - 15;
        if (walk_v > 4095)
        begin
            walk_v = 4095;
            walk_drift = -walk_drift;
        end
        if (walk_v < 0)
        begin
            walk_v = 0;
            walk_drift = -walk_drift;
        end
        s.voltage = bcrc_pkg::code_t'(walk_v);

        r = $urandom_range(0, 99);
        if (r < 5)
            s.current = '0;
        else if (r < 10)
            s.current = '1;
        else
            s.current = bcrc_pkg::code_t'($urandom_range(0, 4095));

        r = $urandom_range(0, 99);
        if (r < 5)
            s.temp = '0;
        else if (r < 12)
            s.temp = bcrc_pkg::code_t'($urandom_range(thr_hot, 4095));
        else if (r < 15)
            s.temp = '1;
        else if (thr_hot > 1)
            s.temp = bcrc_pkg::code_t'($urandom_range(1, thr_hot - 1));
        else
            s.temp = bcrc_pkg::code_t'($urandom_range(0, 4095));

        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            s.cmd = bcrc_pkg::CMD_IDLE;
            walk_drift = 0;
        end
        else if (r < 9)
        begin
            s.cmd = bcrc_pkg::CMD_CHARGE;
            walk_drift = 4;
        end
        else if (r < 13)
        begin
            s.cmd = bcrc_pkg::CMD_DISCHARGE;
            walk_drift = -4;
        end
        else
            s.cmd = bcrc_pkg::CMD_NONE;
        return s;
    endfunction

    task automatic queue_random(int count);
        loop_sample_t s;
        for (int n = 0; n < count; n++)
        begin
            s = random_sample();
            // enter the first wrap while charging
            if (items_queued == bcrc_pkg::WINDOW - 2)
                s.cmd = bcrc_pkg::CMD_CHARGE;
            sample_queue.push_back(s);
            items_queued++;
        end
    endtask

    task automatic write_threshold(logic [bcrc_pkg::CFG_INDEX_W-1:0] idx,
                                   bcrc_pkg::code_t value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            bcrc_pkg::CFG_CHARGE_CUTOFF:    thr_charge = value;
            bcrc_pkg::CFG_DISCHARGE_CUTOFF: thr_discharge = value;
            bcrc_pkg::CFG_HOT:              thr_hot = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_axis_tvalid || relay_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                relay_expected.push_back(advance_controller(sample_in_flight));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    sample_in_flight = sample_queue.pop_front();
                    s_axis_tdata <= bcrc_pkg::IN_TDATA_W'({sample_in_flight.cmd,
                                                           sample_in_flight.temp,
                                                           sample_in_flight.current,
                                                           sample_in_flight.voltage});
                    s_axis_tvalid <= 1'b1;
                    send_gap = phase_calm ? 0 : pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and checker
    always @(posedge clk)
    begin
        bcrc_pkg::result_t want;
        int                r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (relay_expected.size() == 0)
                begin
                    $error("result item with nothing expected: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = relay_expected.pop_front();
                    if (m_axis_tdata[1:0] !== want.mode)
                    begin
                        $error("relay_mode: expected %0d, got %0d", want.mode, m_axis_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[2] !== want.relay_one)
                    begin
                        $error("relay_one: expected %0d, got %0d", want.relay_one, m_axis_tdata[2]);
                        mismatches++;
                    end
                    if (m_axis_tdata[3] !== want.relay_two)
                    begin
                        $error("relay_two: expected %0d, got %0d", want.relay_two, m_axis_tdata[3]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15:4] !== want.avg_voltage)
                    begin
                        $error("avg_voltage: expected %0d, got %0d", want.avg_voltage,
                               m_axis_tdata[15:4]);
                        mismatches++;
                    end
                    if (m_axis_tdata[27:16] !== want.avg_current)
                    begin
                        $error("avg_current: expected %0d, got %0d", want.avg_current,
                               m_axis_tdata[27:16]);
                        mismatches++;
                    end
                    if (m_axis_tdata[28] !== want.window_full)
                    begin
                        $error("window_full: expected %0d, got %0d", want.window_full,
                               m_axis_tdata[28]);
                        mismatches++;
                    end
                end
                results_checked++;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (results_checked >= LONG_HOLD_AT && !long_hold_done)
            begin
                // long back-pressure: the input side has to fill and stall
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (phase_calm)
                m_axis_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    hold_left = $urandom_range(20, 60);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= (r >= 30);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < bcrc_pkg::WINDOW; k++)
        begin
            volt_ring[k] = '0;
            amp_ring[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds; field extremes and every command before the window fills
        @(negedge clk);
        sample_queue.push_back(make_sample(0, 0, 0, bcrc_pkg::CMD_NONE));
        sample_queue.push_back(make_sample(4095, 4095, 4095, bcrc_pkg::CMD_NONE));
        sample_queue.push_back(make_sample(4095, 0, 4095, bcrc_pkg::CMD_CHARGE));
        sample_queue.push_back(make_sample(0, 4095, 0, bcrc_pkg::CMD_DISCHARGE));
        sample_queue.push_back(make_sample(2769, 1868, 2851, bcrc_pkg::CMD_IDLE));
        sample_queue.push_back(make_sample(2768, 1, 2850, bcrc_pkg::CMD_CHARGE));
        sample_queue.push_back(make_sample(1868, 4094, 2852, bcrc_pkg::CMD_NONE));
        sample_queue.push_back(make_sample(1867, 2048, 1, bcrc_pkg::CMD_DISCHARGE));
        sample_queue.push_back(make_sample(4095, 4095, 0, bcrc_pkg::CMD_CHARGE));
        sample_queue.push_back(make_sample(0, 0, 4095, bcrc_pkg::CMD_IDLE));
        sample_queue.push_back(make_sample(12'hAAA, 12'h555, 12'hAAA, bcrc_pkg::CMD_DISCHARGE));
        sample_queue.push_back(make_sample(12'h555, 12'hAAA, 12'h555, bcrc_pkg::CMD_CHARGE));
        sample_queue.push_back(make_sample(4095, 4095, 4095, bcrc_pkg::CMD_NONE));
        sample_queue.push_back(make_sample(0, 0, 0, bcrc_pkg::CMD_NONE));
        items_queued = sample_queue.size();
        walk_v = 2300;
        queue_random(275);
        wait_drained();

        // Cutoffs at the far ends, hottest code, and a write to the unused index
        write_threshold(bcrc_pkg::CFG_CHARGE_CUTOFF, 12'd4095);
        write_threshold(bcrc_pkg::CFG_DISCHARGE_CUTOFF, 12'd0);
        write_threshold(bcrc_pkg::CFG_HOT, 12'd4095);
        write_threshold(CFG_SPARE_INDEX, 12'h123);
        settings_used++;
        @(negedge clk);
        queue_random(240);
        wait_drained();

        // Inverted cutoffs and a zero hot code
        write_threshold(bcrc_pkg::CFG_CHARGE_CUTOFF, 12'd0);
        write_threshold(bcrc_pkg::CFG_DISCHARGE_CUTOFF, 12'd4095);
        write_threshold(bcrc_pkg::CFG_HOT, 12'd0);
        settings_used++;
        @(negedge clk);
        queue_random(240);
        wait_drained();

        write_threshold(bcrc_pkg::CFG_CHARGE_CUTOFF,
                        bcrc_pkg::code_t'($urandom_range(2000, 3200)));
        write_threshold(bcrc_pkg::CFG_DISCHARGE_CUTOFF,
                        bcrc_pkg::code_t'($urandom_range(1200, 2200)));
        write_threshold(bcrc_pkg::CFG_HOT, bcrc_pkg::code_t'($urandom_range(1500, 3800)));
        settings_used++;
        @(negedge clk);
        walk_v = int'(thr_discharge);
        queue_random(240);
        wait_drained();

        // Back to reset values, full rate on both sides
        write_threshold(bcrc_pkg::CFG_CHARGE_CUTOFF, bcrc_pkg::CHARGE_CUTOFF_RST);
        write_threshold(bcrc_pkg::CFG_DISCHARGE_CUTOFF, bcrc_pkg::DISCHARGE_CUTOFF_RST);
        write_threshold(bcrc_pkg::CFG_HOT, bcrc_pkg::HOT_RST);
        settings_used++;
        @(negedge clk);
        phase_calm = 1'b1;
        queue_random(240);
        wait_drained();
        phase_calm = 1'b0;
        repeat (20) @(negedge clk);

        $display("checked %0d of %0d items under %0d threshold settings, incl. zero hot code",
                 results_checked, items_accepted, settings_used);
        $display("relay events: %0d charge cutoffs, %0d discharge cutoffs, %0d overheat trips",
                 charge_stops, discharge_stops, hot_trips);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
